@@ rtl/core/prq_pkg.sv @@
package prq_pkg;

  // Fixed field widths
  localparam int TASK_W = 4;
  localparam int PRIO_W = 4;

  // Operation codes
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Contents of one queue slot
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic              put;
    logic              get;
    logic              preempted;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

@@ rtl/core/prq_cell.sv @@
module prq_cell
  import prq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  slot_t left_slot,
  input  logic  left_behind,
  input  slot_t right_slot,
  output slot_t slot,
  output logic  behind
);

  slot_t slot_next;

  // New entry stays behind this slot: strictly higher, or equal when newly activated
  always_comb begin
    if (cmd.preempted) begin
      behind = slot.valid && (slot.prio > cmd.prio);
    end else begin
      behind = slot.valid && (slot.prio >= cmd.prio);
    end
  end

  // Insert shifts towards the tail, get shifts towards the head
  always_comb begin
    slot_next = slot;
    if (cmd.get) begin
      slot_next = right_slot;
    end else if (cmd.put && !behind) begin
      if (left_behind) begin
        slot_next.valid   = 1'b1;
        slot_next.task_id = cmd.task_id;
        slot_next.prio    = cmd.prio;
      end else begin
        slot_next = left_slot;
      end
    end
  end

  // Slot register, cleared to an empty zero entry under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

@@ rtl/core/priority_ready_queue.sv @@
// A result strobes on done in the cycle after the transaction is taken.
// Throughput: one put or get per cycle; busy stays low, as every cell of the
// slot chain applies its insert or shift directly to its slot register.
// Reset: synchronous rst empties the queue (all slot valid bits cleared).
// The receiver cannot stall: each result is shown for exactly one cycle.
module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int TASKS           = 16,
  parameter int PRIORITY_LEVELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [TASK_W-1:0] task_id,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic              preempted,
  output logic              done,
  output logic              found,
  output logic [TASK_W-1:0] out_task,
  output logic [PRIO_W-1:0] out_priority,
  output logic              full_error
);

  localparam int CMP_W = 9;
  localparam logic [CMP_W-1:0] PRIO_MAX = CMP_W'(PRIORITY_LEVELS - 1);

  slot_t            slots [TASKS];
  logic [TASKS-1:0] behind;
  cmd_t             cmd;
  logic             full;
  logic             empty;
  logic [PRIO_W-1:0] prio_sat;

  assign busy  = 1'b0;
  assign full  = slots[TASKS-1].valid;
  assign empty = !slots[0].valid;

  // Saturate priority to the configured levels
  always_comb begin
    if (CMP_W'(priority_req) > PRIO_MAX) begin
      prio_sat = PRIO_MAX[PRIO_W-1:0];
    end else begin
      prio_sat = priority_req;
    end
  end

  // Broadcast command; dropped puts and empty gets leave the chain alone
  always_comb begin
    cmd.put       = start && (operation == OP_PUT) && !full;
    cmd.get       = start && (operation == OP_GET) && !empty;
    cmd.preempted = preempted;
    cmd.task_id   = task_id;
    cmd.prio      = prio_sat;
  end

  // Chain of slot cells, slot 0 is the head
  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_b;

    if (i == 0) begin : g_head
      assign left_s = '0;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_s = slots[i-1];
      assign left_b = behind[i-1];
    end

    if (i == TASKS - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_body
      assign right_s = slots[i+1];
    end

    prq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_slot  (left_s),
      .left_behind(left_b),
      .right_slot (right_s),
      .slot       (slots[i]),
      .behind     (behind[i])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      found        <= 1'b0;
      out_task     <= '0;
      out_priority <= '0;
      full_error   <= 1'b0;
    end else begin
      done         <= start;
      found        <= cmd.get;
      out_task     <= cmd.get ? slots[0].task_id : '0;
      out_priority <= cmd.get ? slots[0].prio : '0;
      full_error   <= start && (operation == OP_PUT) && full;
    end
  end

  // Checks
  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("done without a transaction");

  a_found_only_on_get : assert property (@(posedge clk) disable iff (rst)
    found |-> ($past(operation) == OP_GET) && $past(slots[0].valid))
    else $error("found without a valid head");

  a_full_only_on_put : assert property (@(posedge clk) disable iff (rst)
    full_error |-> ($past(operation) == OP_PUT) && $past(full))
    else $error("full_error without a full queue");

  a_head_ordered : assert property (@(posedge clk) disable iff (rst)
    (TASKS > 1) && slots[1].valid |-> slots[0].valid && (slots[0].prio >= slots[1].prio))
    else $error("head slots out of priority order");

endmodule
